FILE: rtl/pisl_pkg.sv
// ----------------------------------------------------------------------------
// pisl_pkg: shared types and constants for the clamped PI/PID speed loop
// Register indexes, loop modes and the fixed field widths of the controller.
// ----------------------------------------------------------------------------
package pisl_pkg;

	// Fixed widths of the item fields and the configuration port.
	localparam int CHAN_W   = 3;
	localparam int SPEED_W  = 16;
	localparam int ERR_W    = SPEED_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int GAIN_W   = 16;
	localparam int SEP_W    = 16;
	localparam int ILIM_W   = 31;
	localparam int OLIM_W   = 15;
	localparam int INTEG_W  = 32;
	localparam int DRIVE_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	// Sum of the three terms, wide enough for the integral product plus carries.
	localparam int SUM_W    = 50;

	// Error magnitude at or below which gimbal mode drives zero.
	localparam int DEADBAND = 2;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_CHASSIS = 2'd1,
		MODE_TRIGGER = 2'd2,
		MODE_GIMBAL  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_MODE        = 3'd0,
		REG_GAIN_P           = 3'd1,
		REG_GAIN_I           = 3'd2,
		REG_GAIN_D           = 3'd3,
		REG_SEPARATION_LIMIT = 3'd4,
		REG_INTEGRAL_LIMIT   = 3'd5,
		REG_OUTPUT_LIMIT     = 3'd6
	} cfg_reg_t;

endpackage

FILE: rtl/pi_pid_speed_loop_clamped_core.sv
// ----------------------------------------------------------------------------
// pi_pid_speed_loop_clamped_core: multi-channel PI/PID speed controller
// Integral separation, integral and output clamping, gimbal deadband.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register and, when it moves on,
// its result is loaded into the result register and presented from then on.
// Throughput: one item per cycle unless the result side stalls; a single
// input register feeds one multiply-add-clamp pass into the result register.
// Reset: arst_n clears the configuration registers, all channel state and the
// valid flags of both stages; the payload registers are not reset.
// ----------------------------------------------------------------------------
module pi_pid_speed_loop_clamped_core #(
	parameter int CHANNELS       = 8,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [pisl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pisl_pkg::CFG_DATA_W-1:0]       cfg_data,

	// Input item channel.
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [pisl_pkg::CHAN_W-1:0]           channel,
	input  logic signed [pisl_pkg::SPEED_W-1:0]   speed_setpoint,
	input  logic signed [pisl_pkg::SPEED_W-1:0]   measured_speed,

	// Result item channel.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [pisl_pkg::CHAN_W-1:0]           out_channel,
	output logic signed [pisl_pkg::DRIVE_W-1:0]   drive,
	output logic                                  saturated
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [6:0] CHAN_COUNT = 7'(CHANNELS);

	localparam int CHAN_W  = pisl_pkg::CHAN_W;
	localparam int SPEED_W = pisl_pkg::SPEED_W;
	localparam int ERR_W   = pisl_pkg::ERR_W;
	localparam int DIFF_W  = pisl_pkg::DIFF_W;
	localparam int GAIN_W  = pisl_pkg::GAIN_W;
	localparam int INTEG_W = pisl_pkg::INTEG_W;
	localparam int DRIVE_W = pisl_pkg::DRIVE_W;
	localparam int SUM_W   = pisl_pkg::SUM_W;

	// ------------------------------------------------------------------------
	// Configuration registers. Software writes these only while the block is
	// idle, which the block does not enforce; the datapath reads them directly.
	// ------------------------------------------------------------------------
	pisl_pkg::mode_t                 mode_q;
	logic [GAIN_W-1:0]               gain_p_q;
	logic [GAIN_W-1:0]               gain_i_q;
	logic [GAIN_W-1:0]               gain_d_q;
	logic [pisl_pkg::SEP_W-1:0]      sep_limit_q;
	logic [pisl_pkg::ILIM_W-1:0]     integ_limit_q;
	logic [pisl_pkg::OLIM_W-1:0]     out_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= pisl_pkg::MODE_IDLE;
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			sep_limit_q   <= '0;
			integ_limit_q <= '0;
			out_limit_q   <= '0;
		end else if (cfg_we) begin
			case (pisl_pkg::cfg_reg_t'(cfg_index))
				pisl_pkg::REG_LOOP_MODE:        mode_q <= pisl_pkg::mode_t'(cfg_data[1:0]);
				pisl_pkg::REG_GAIN_P:           gain_p_q <= cfg_data[GAIN_W-1:0];
				pisl_pkg::REG_GAIN_I:           gain_i_q <= cfg_data[GAIN_W-1:0];
				pisl_pkg::REG_GAIN_D:           gain_d_q <= cfg_data[GAIN_W-1:0];
				pisl_pkg::REG_SEPARATION_LIMIT: sep_limit_q <= cfg_data[pisl_pkg::SEP_W-1:0];
				pisl_pkg::REG_INTEGRAL_LIMIT:   integ_limit_q <= cfg_data[pisl_pkg::ILIM_W-1:0];
				pisl_pkg::REG_OUTPUT_LIMIT:     out_limit_q <= cfg_data[pisl_pkg::OLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Handshake. Stage 1 is the input register, stage 2 the result register.
	// The result register moves on whenever it is empty or being taken, and
	// the input register moves into it in the same cycle, so one item per
	// cycle flows through while the result side keeps up. When the result
	// side stalls, one more item can still be taken into stage 1.
	// ------------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic s2_free;
	logic fire_s1;
	logic take_in;

	assign s2_free    = !valid_s2 || !result_stall;
	assign fire_s1    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign take_in    = item_valid && !item_stall;

	logic [CHAN_W-1:0]          channel_s1;
	logic signed [SPEED_W-1:0]  target_s1;
	logic signed [SPEED_W-1:0]  measured_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			channel_s1  <= channel;
			target_s1   <= speed_setpoint;
			measured_s1 <= measured_speed;
		end
	end

	// ------------------------------------------------------------------------
	// Per-channel loop state. The item in stage 1 reads its channel's entry;
	// the entry is rewritten at the edge where that item moves into the
	// result register, so the next item on the same channel, arriving in
	// stage 1 at that very edge, already sees the updated values.
	// ------------------------------------------------------------------------
	logic signed [INTEG_W-1:0] integ_q      [CHANNELS];
	logic signed [ERR_W-1:0]   prev_err_q   [CHANNELS];
	logic signed [DRIVE_W-1:0] prev_drive_q [CHANNELS];

	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic             is_idle;
	logic             is_gimbal;

	assign idx       = IDX_W'(channel_s1);
	assign in_range  = {4'd0, channel_s1} < CHAN_COUNT;
	assign is_idle   = (mode_q == pisl_pkg::MODE_IDLE);
	assign is_gimbal = (mode_q == pisl_pkg::MODE_GIMBAL);

	// Speed error and its magnitude.
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        err_mag;
	logic                    sep_ok;
	logic                    in_deadband;

	assign err         = {target_s1[SPEED_W-1], target_s1}
	                   - {measured_s1[SPEED_W-1], measured_s1};
	assign err_mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign sep_ok      = err_mag <= {1'b0, sep_limit_q};
	assign in_deadband = is_gimbal && (err_mag <= ERR_W'(pisl_pkg::DEADBAND));

	// Integral with separation, then the anti-windup clamp. The clamp runs on
	// every active step, so lowering the limit pulls the integral in even
	// when the error is too large to be added.
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W:0]   integ_lim;
	logic signed [INTEG_W-1:0] integ_new;

	assign integ_sum = {integ_q[idx][INTEG_W-1], integ_q[idx]}
	                 + (sep_ok ? (INTEG_W+1)'(err) : '0);
	assign integ_lim = $signed({2'b00, integ_limit_q});

	always_comb begin
		if (integ_sum > integ_lim) begin
			integ_new = INTEG_W'(integ_lim);
		end else if (integ_sum < -integ_lim) begin
			integ_new = INTEG_W'(-integ_lim);
		end else begin
			integ_new = integ_sum[INTEG_W-1:0];
		end
	end

	// The three terms, each gain times operand with GAIN_FRAC_BITS fractional
	// bits, added exactly. The derivative term only counts in gimbal mode.
	logic signed [DIFF_W-1:0]        err_diff;
	logic signed [GAIN_W+ERR_W:0]    p_term;
	logic signed [GAIN_W+INTEG_W:0]  i_term;
	logic signed [GAIN_W+DIFF_W:0]   d_term;
	logic signed [SUM_W-1:0]         sum;

	assign err_diff = {err[ERR_W-1], err} - {prev_err_q[idx][ERR_W-1], prev_err_q[idx]};
	assign p_term   = $signed({1'b0, gain_p_q}) * err;
	assign i_term   = $signed({1'b0, gain_i_q}) * integ_new;
	assign d_term   = $signed({1'b0, gain_d_q}) * err_diff;
	assign sum      = SUM_W'(p_term) + SUM_W'(i_term)
	                + (is_gimbal ? SUM_W'(d_term) : '0);

	// Output clamp against the limit scaled into the fixed-point format, and
	// truncation toward zero when the sum lies inside it.
	logic [SUM_W-1:0]           bound_u;
	logic signed [SUM_W-1:0]    bound;
	logic [SUM_W-1:0]           sum_mag;
	logic [SUM_W-1:0]           sum_int;
	logic signed [DRIVE_W-1:0]  drive_trunc;
	logic signed [DRIVE_W-1:0]  drive_lim;

	assign bound_u     = SUM_W'(out_limit_q) << GAIN_FRAC_BITS;
	assign bound       = $signed(bound_u);
	assign sum_mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign sum_int     = sum_mag >> GAIN_FRAC_BITS;
	assign drive_trunc = sum[SUM_W-1] ? DRIVE_W'(-sum_int[DRIVE_W-1:0])
	                                  : $signed(sum_int[DRIVE_W-1:0]);
	assign drive_lim   = $signed({1'b0, out_limit_q});

	logic signed [DRIVE_W-1:0] drive_next;
	logic                      sat_next;

	always_comb begin
		drive_next = '0;
		sat_next   = 1'b0;
		if (!in_range) begin
			drive_next = '0;
		end else if (is_idle) begin
			drive_next = prev_drive_q[idx];
		end else if (in_deadband) begin
			drive_next = '0;
		end else if (sum > bound) begin
			drive_next = drive_lim;
			sat_next   = 1'b1;
		end else if (sum < -bound) begin
			drive_next = -drive_lim;
			sat_next   = 1'b1;
		end else begin
			drive_next = drive_trunc;
		end
	end

	// State update: only active modes on an existing channel change state;
	// the previous error moves in gimbal mode only.
	logic state_we;

	assign state_we = fire_s1 && in_range && !is_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				integ_q[k]      <= '0;
				prev_err_q[k]   <= '0;
				prev_drive_q[k] <= '0;
			end
		end else if (state_we) begin
			integ_q[idx]      <= integ_new;
			prev_drive_q[idx] <= drive_next;
			if (is_gimbal) begin
				prev_err_q[idx] <= err;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------------
	logic [CHAN_W-1:0]          channel_s2;
	logic signed [DRIVE_W-1:0]  drive_s2;
	logic                       sat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			channel_s2 <= channel_s1;
			drive_s2   <= drive_next;
			sat_s2     <= sat_next;
		end
	end

	assign result_valid = valid_s2;
	assign out_channel  = channel_s2;
	assign drive        = drive_s2;
	assign saturated    = sat_s2;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------

	// An item leaving the input register shows up as the next result, with
	// its own channel.
	a_fire_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> result_valid && (out_channel == $past(channel_s1)))
		else $error("item leaving stage 1 did not reach the result register");

	// An item held in the input register keeps its payload until it moves on.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire_s1) |=> valid_s1 && $stable(channel_s1)
			&& $stable(target_s1) && $stable(measured_s1))
		else $error("stage 1 item changed while waiting");

	// A stalled result stays on the output unchanged.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid && $stable(out_channel)
			&& $stable(drive) && $stable(saturated))
		else $error("stalled result changed while waiting");

endmodule
